>>> design/tkbh_pkg.sv
// Shared types and constants for the typed key bucket hash core.
package tkbh_pkg;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CNT_W   = 6;

    localparam logic [HASH_W-1:0]  FNV_BASIS     = 64'd2166136261;
    // The FNV prime is 2^24 + 403, so the multiply is a shift plus a narrow product.
    localparam int unsigned        FNV_SHIFT     = 24;
    localparam logic [8:0]         FNV_PRIME_LO  = 9'd403;
    localparam int unsigned        DJB_SHIFT     = 5;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 32'd1024;

    localparam logic [1:0] KIND_INT8  = 2'd0;
    localparam logic [1:0] KIND_INT32 = 2'd1;
    localparam logic [1:0] KIND_INT64 = 2'd2;
    localparam logic [1:0] KIND_STR   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_BUCKET = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST_DIV = 6'd63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FNV,
        ST_DIV,
        ST_DONE
    } tkbh_state_t;

    typedef struct packed {
        logic       load_int;
        logic       fnv_step;
        logic       str_seed;
        logic       str_step;
        logic       str_end;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic [1:0] out_status;
    } tkbh_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       byte_zero;
        logic       started;
        logic       count_zero;
    } tkbh_stat_t;

endpackage

>>> design/tkbh_ctrl.sv
// Controller state machine: sequences hashing, division and result hand-off.
module tkbh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    input  logic                result_stall,
    input  tkbh_pkg::tkbh_stat_t stat,
    output tkbh_pkg::tkbh_cmd_t  cmd,
    output logic                key_stall,
    output logic                result_valid
);
    import tkbh_pkg::*;

    tkbh_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign accept   = (state_reg == ST_IDLE) && key_valid;
    assign out_free = !out_valid_reg || !result_stall;

    // Next state, step counter and pending status.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.kind == KIND_STR)
                    begin
                        if (stat.byte_zero && !stat.started)
                        begin
                            pend_next  = stat.count_zero ? STATUS_NO_BUCKET : STATUS_EMPTY;
                            state_next = ST_DONE;
                        end
                        else if (stat.byte_zero)
                        begin
                            if (stat.count_zero)
                            begin
                                pend_next  = STATUS_NO_BUCKET;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = ST_DIV;
                            end
                        end
                    end
                    else
                    begin
                        unique case (stat.kind)
                            KIND_INT8:  cnt_next = CNT_W'(0);
                            KIND_INT32: cnt_next = CNT_W'(3);
                            default:    cnt_next = CNT_W'(7);
                        endcase
                        state_next = ST_FNV;
                    end
                end
            end
            ST_FNV:
            begin
                if (cnt_reg == '0)
                begin
                    if (stat.count_zero)
                    begin
                        pend_next  = STATUS_NO_BUCKET;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST_DIV)
                begin
                    pend_next  = STATUS_OK;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        cmd.out_status = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.kind == KIND_STR)
                    begin
                        cmd.str_seed  = !stat.started && !stat.byte_zero;
                        cmd.str_step  = stat.started && !stat.byte_zero;
                        cmd.str_end   = stat.started && stat.byte_zero;
                        cmd.div_start = stat.started && stat.byte_zero;
                    end
                    else
                    begin
                        cmd.load_int = 1'b1;
                    end
                end
            end
            ST_FNV:
            begin
                cmd.fnv_step  = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign key_stall    = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

>>> design/tkbh_dp.sv
// Datapath: hash registers, string state, bit-serial remainder and result register.
module tkbh_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 key_kind,
    input  logic [tkbh_pkg::HASH_W-1:0] key_data,
    input  logic                       cfg_write,
    input  logic [tkbh_pkg::COUNT_W-1:0] cfg_data,
    input  tkbh_pkg::tkbh_cmd_t         cmd,
    output tkbh_pkg::tkbh_stat_t        stat,
    output logic [tkbh_pkg::COUNT_W-1:0] bucket_index,
    output logic [1:0]                 status
);
    import tkbh_pkg::*;

    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [HASH_W-1:0]  key_reg, key_next;
    logic [HASH_W-1:0]  str_hash_reg, str_hash_next;
    logic               started_reg, started_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] index_reg;
    logic [1:0]         status_reg;

    logic [HASH_W-1:0]  fnv_mix;
    logic [HASH_W-1:0]  fnv_lo;
    logic [HASH_W-1:0]  byte_ext;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;

    assign byte_ext = {{(HASH_W-8){1'b0}}, key_data[7:0]};
    assign fnv_mix  = hash_reg ^ {{(HASH_W-8){1'b0}}, key_reg[7:0]};
    assign fnv_lo   = fnv_mix * FNV_PRIME_LO;

    // Restoring division step: shift in the next dividend bit and subtract if it fits.
    assign trial = {rem_reg, hash_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, count_reg};

    always_comb
    begin
        hash_next     = hash_reg;
        key_next      = key_reg;
        str_hash_next = str_hash_reg;
        started_next  = started_reg;
        rem_next      = rem_reg;
        if (cmd.load_int)
        begin
            hash_next = FNV_BASIS;
            key_next  = key_data;
        end
        if (cmd.fnv_step)
        begin
            hash_next = (fnv_mix << FNV_SHIFT) + fnv_lo;
            key_next  = key_reg >> 8;
        end
        if (cmd.str_seed)
        begin
            str_hash_next = byte_ext;
            started_next  = 1'b1;
        end
        if (cmd.str_step)
        begin
            str_hash_next = ((str_hash_reg << DJB_SHIFT) + str_hash_reg) ^ byte_ext;
        end
        if (cmd.str_end)
        begin
            hash_next     = str_hash_reg;
            str_hash_next = '0;
            started_next  = 1'b0;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            hash_next = hash_reg << 1;
            rem_next  = diff[COUNT_W] ? trial[COUNT_W-1:0] : diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            str_hash_reg <= '0;
            started_reg  <= 1'b0;
            count_reg    <= COUNT_RESET;
        end
        else
        begin
            str_hash_reg <= str_hash_next;
            started_reg  <= started_next;
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        key_reg  <= key_next;
        rem_reg  <= rem_next;
        if (cmd.out_load)
        begin
            index_reg  <= (cmd.out_status == STATUS_OK) ? rem_reg : '0;
            status_reg <= cmd.out_status;
        end
    end

    assign stat.kind       = key_kind;
    assign stat.byte_zero  = (key_data[7:0] == 8'd0);
    assign stat.started    = started_reg;
    assign stat.count_zero = (count_reg == '0);

    assign bucket_index = index_reg;
    assign status       = status_reg;

endmodule

>>> design/typed_key_bucket_hash_core.sv
// Top level of the typed key bucket hash core.
//
// Key channel (key_valid/key_stall, key_kind, key_data): one item per key
// or per string byte. Integer keys (8, 32, 64 bit) are hashed FNV-1a style
// one byte per cycle, then reduced modulo bucket_count by a restoring
// divider that retires one quotient bit per cycle.
// Result channel (result_valid/result_stall, bucket_index, status) carries
// one item per integer key and per terminating zero string byte.
// Steps per item: an integer key is accepted, hashed in 1, 4 or 8 FNV steps,
// divided in 64 restoring divide steps and handed off to the output register.
// A nonzero string byte only updates the string hash and produces no result.
// With a zero bucket count the divide is skipped and status is reported.
// The result sits in an output register: a new key is taken while it waits.
// If the receiver stalls while another result is ready, the core holds in
// its done state and key_stall stays high until the register frees.
// Reset clears the string state, empties the output and sets the count to 1024.
// cfg_valid/cfg_ready writes bucket_count; it is always ready.
module typed_key_bucket_hash_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         key_valid,
    output logic                         key_stall,
    input  logic [1:0]                   key_kind,
    input  logic [tkbh_pkg::HASH_W-1:0]  key_data,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [tkbh_pkg::COUNT_W-1:0] bucket_index,
    output logic [1:0]                   status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tkbh_pkg::COUNT_W-1:0] cfg_data
);
    import tkbh_pkg::*;

    tkbh_cmd_t  cmd;
    tkbh_stat_t stat;

    assign cfg_ready = 1'b1;

    tkbh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd),
        .key_stall    (key_stall),
        .result_valid (result_valid)
    );

    tkbh_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_kind     (key_kind),
        .key_data     (key_data),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .bucket_index (bucket_index),
        .status       (status)
    );

endmodule

>>> design/tkbh_chk.sv
// Port-level checker for the typed key bucket hash core, with its bind.
module tkbh_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         key_valid,
    input logic                         key_stall,
    input logic [1:0]                   key_kind,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [tkbh_pkg::COUNT_W-1:0] bucket_index,
    input logic [1:0]                   status
);
    import tkbh_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(bucket_index)
            && $stable(status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STATUS_OK || status == STATUS_NO_BUCKET
            || status == STATUS_EMPTY))
        else $error("undefined status code");

    // An error result never carries a bucket.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_OK |-> bucket_index == '0)
        else $error("error result with nonzero bucket");

    // An integer key always keeps the core busy for at least the next cycle.
    a_int_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key_kind != KIND_STR |=> key_stall)
        else $error("integer key did not occupy the core");

endmodule

bind typed_key_bucket_hash_core tkbh_chk u_tkbh_chk (.*);
